### rtl/core/rrwc_pkg.sv
// Shared types and constants for the reverse realigning word copy block.
// Used by rrwc_build, rrwc_res_fifo and reverse_realigning_word_copy.
package rrwc_pkg;

  localparam int unsigned DEFAULT_WORD_BYTES = 8;
  localparam int unsigned DATA_W             = 64;
  localparam int unsigned BE_W               = 8;
  localparam int unsigned POS_W              = 30;
  localparam int unsigned LEN_W              = 32;
  localparam int unsigned LANE_W             = 3;
  localparam int unsigned SPAN_W             = LEN_W + 1;
  // Lane arithmetic width: holds lane indexes up to twice the widest word.
  localparam int unsigned IDX_W              = 5;
  localparam int unsigned CFG_IDX_W          = 2;
  localparam int unsigned CFG_DATA_W         = 32;
  localparam int unsigned IN_TDATA_W         = 64;
  localparam int unsigned OUT_TDATA_W        = 104;
  localparam int unsigned RES_DEPTH          = 3;
  localparam int unsigned RES_CNT_W          = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_END_LANE = 2'd0,
    REG_DST_END_LANE = 2'd1,
    REG_BYTE_LENGTH  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_HEAD   = 2'd0,
    PH_STREAM = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef struct packed {
    logic              final_word;
    logic [POS_W-1:0]  word_back_index;
    logic [BE_W-1:0]   byte_enable;
    logic [DATA_W-1:0] dst_word;
  } res_t;

  // Reduces a configured end lane modulo the word size by repeated subtraction.
  function automatic logic [LANE_W-1:0] lane_mod(logic [LANE_W-1:0] v, int unsigned wb);
    logic [LANE_W-1:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (int'(r) >= int'(wb)) begin
        r = LANE_W'(int'(r) - int'(wb));
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/rrwc_build.sv
// Builds one destination word: byte shift-merge of two source words plus its lane mask.
// Depends on rrwc_pkg.
module rrwc_build import rrwc_pkg::*; #(
  parameter int unsigned WORD_BYTES = DEFAULT_WORD_BYTES,
  localparam int unsigned LW        = $clog2(WORD_BYTES),
  localparam int unsigned BASE_W    = POS_W + LW
) (
  input  logic [DATA_W-1:0] older_i,
  input  logic [DATA_W-1:0] newer_i,
  input  logic [LW-1:0]     shift_i,
  input  logic [LW-1:0]     md_i,
  input  logic [SPAN_W-1:0] span_i,
  input  logic [BASE_W-1:0] base_i,
  input  logic [POS_W-1:0]  pos_i,
  output res_t              res_o,
  output logic              any_o
);

  localparam int unsigned DIFF_W    = ((BASE_W > SPAN_W) ? BASE_W : SPAN_W) + 1;
  localparam int unsigned OUT_LANES = (WORD_BYTES < 8) ? WORD_BYTES : 8;

  function automatic logic [7:0] pick(logic [DATA_W-1:0] w, logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = '0;
    if (idx < IDX_W'(8)) begin
      b = w[{idx[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  logic signed [DIFF_W-1:0] hi_s;
  logic [IDX_W-1:0]         hi_c;
  logic [IDX_W-1:0]         lo_c;
  logic [WORD_BYTES-1:0]    en;
  logic [DATA_W-1:0]        word;
  logic [BE_W-1:0]          be;

  // hi_s counts range bytes from the bottom of this word up to the top of the range.
  always_comb begin
    hi_s = $signed(DIFF_W'(span_i)) - $signed(DIFF_W'(base_i));
    if (hi_s <= 0) begin
      hi_c = '0;
    end else if (hi_s > $signed(DIFF_W'(WORD_BYTES))) begin
      hi_c = IDX_W'(WORD_BYTES);
    end else begin
      hi_c = hi_s[IDX_W-1:0];
    end
    // Only the word that holds the last destination byte has a top margin.
    lo_c = (base_i == '0) ? IDX_W'(md_i) : '0;
  end

  always_comb begin
    logic [IDX_W-1:0] j;
    en = '0;
    for (int l = 0; l < WORD_BYTES; l++) begin
      j     = IDX_W'(WORD_BYTES - 1 - l);
      en[l] = (j >= lo_c) && (j < hi_c);
    end
  end

  always_comb begin
    logic [IDX_W-1:0] lv;
    logic [IDX_W-1:0] sv;
    word = '0;
    be   = '0;
    sv   = IDX_W'(shift_i);
    for (int l = 0; l < OUT_LANES; l++) begin
      lv = IDX_W'(l);
      if (sv == '0) begin
        word[8*l +: 8] = pick(newer_i, lv);
      end else if (lv >= sv) begin
        word[8*l +: 8] = pick(older_i, lv - sv);
      end else begin
        word[8*l +: 8] = pick(newer_i, lv + IDX_W'(WORD_BYTES) - sv);
      end
      be[l] = en[l];
    end
  end

  assign any_o                 = |en;
  assign res_o.dst_word        = word;
  assign res_o.byte_enable     = be;
  assign res_o.word_back_index = pos_i;
  assign res_o.final_word      = (hi_s >= 1) && (hi_s <= $signed(DIFF_W'(WORD_BYTES)));

endmodule

### rtl/core/rrwc_res_fifo.sv
// Three-entry result queue that takes up to two words per cycle and hands out one.
// Depends on rrwc_pkg.
module rrwc_res_fifo import rrwc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  res_t       push0_i,
  input  res_t       push1_i,
  output logic       room2_o,
  output logic       valid_o,
  input  logic       ready_i,
  output res_t       head_o
);

  res_t                 entry_q [RES_DEPTH];
  res_t                 entry_d [RES_DEPTH];
  logic [RES_CNT_W-1:0] count_q;
  logic [RES_CNT_W-1:0] count_d;
  logic [RES_CNT_W-1:0] base_idx;
  logic                 pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[0];
  assign room2_o = (count_q <= RES_CNT_W'(RES_DEPTH - 2));

  // Entries shift toward the head on a pop; new words land behind the survivors.
  always_comb begin
    for (int i = 0; i < RES_DEPTH; i++) begin
      if (pop && (i < RES_DEPTH - 1)) begin
        entry_d[i] = entry_q[i+1];
      end else begin
        entry_d[i] = entry_q[i];
      end
    end
    base_idx = count_q - RES_CNT_W'(pop);
    if (push_n_i != 2'd0) begin
      entry_d[base_idx] = push0_i;
    end
    if (push_n_i == 2'd2) begin
      entry_d[base_idx + RES_CNT_W'(1)] = push1_i;
    end
    count_d = base_idx + RES_CNT_W'(push_n_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### rtl/core/reverse_realigning_word_copy.sv
// Descending realigning word copy: shift-merges source words into destination words.
// Throughput: one source word per cycle while the result queue has room for two words;
// output back-pressure or a word that yields two destination words (the end of a copy)
// holds the input while the queue drains. Reset clears the registers and the copy
// state; nothing is copied until byte_length is written. A write to any of the three
// registers restarts the copy; the unused index does not. Depends on rrwc_pkg.
module reverse_realigning_word_copy import rrwc_pkg::*; #(
  parameter int unsigned WORD_BYTES = DEFAULT_WORD_BYTES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [63:0] src_word
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [63:0] dst_word, [71:64] byte_enable,
                                                 // [101:72] word_back_index, zero pad
  output logic                   m_axis_tlast    // final_word
);

  localparam int unsigned LW     = $clog2(WORD_BYTES);
  localparam int unsigned SW     = LW + 1;
  localparam int unsigned BASE_W = POS_W + LW;

  function automatic logic [BASE_W-1:0] base_step(logic [POS_W-1:0] p, logic [BASE_W-1:0] b);
    return (&p) ? '0 : b + BASE_W'(WORD_BYTES);
  endfunction

  // Configuration registers.
  logic [LANE_W-1:0] src_cfg_q, src_cfg_d;
  logic [LANE_W-1:0] dst_cfg_q, dst_cfg_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              restart;

  // Copy state.
  logic [DATA_W-1:0] carry_q, carry_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [BASE_W-1:0] base_q, base_d;
  phase_e            phase_q, phase_d;

  // Input word register.
  logic              in_valid_q, in_valid_d;
  logic [DATA_W-1:0] in_word_q;
  logic              s_accept;
  logic              consume;
  logic              room2;

  // Derived settings.
  logic [LW-1:0]     src_lane, dst_lane, md, shift;
  logic [SW-1:0]     shift_w;
  logic              lag;
  logic [SPAN_W-1:0] span;

  // Step logic.
  logic              head, kill, skip_a, last;
  logic [LEN_W-1:0]  take;
  logic [LEN_W-1:0]  left_next;
  logic [POS_W-1:0]  pos_b;
  logic [BASE_W-1:0] base_b;
  res_t              res_a, res_b, fifo_head;
  logic              any_a, any_b, emit_a, emit_b;
  logic [1:0]        push_n;

  always_comb begin
    src_cfg_d = src_cfg_q;
    dst_cfg_d = dst_cfg_q;
    len_d     = len_q;
    restart   = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_END_LANE: begin
          src_cfg_d = cfg_data_i[LANE_W-1:0];
          restart   = 1'b1;
        end
        REG_DST_END_LANE: begin
          dst_cfg_d = cfg_data_i[LANE_W-1:0];
          restart   = 1'b1;
        end
        REG_BYTE_LENGTH: begin
          len_d   = cfg_data_i[LEN_W-1:0];
          restart = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    src_lane = LW'(lane_mod(src_cfg_q, WORD_BYTES));
    dst_lane = LW'(lane_mod(dst_cfg_q, WORD_BYTES));
    lag      = src_lane < dst_lane;
    md       = LW'(WORD_BYTES - 1) - dst_lane;
    span     = SPAN_W'(len_q) + SPAN_W'(md);
    shift_w  = SW'(dst_lane) + SW'(WORD_BYTES) - SW'(src_lane);
    if (shift_w >= SW'(WORD_BYTES)) begin
      shift_w = shift_w - SW'(WORD_BYTES);
    end
    shift = shift_w[LW-1:0];
  end

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign consume       = in_valid_q && room2;
  assign s_axis_tready = !in_valid_q || consume;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  // The first word of a lagging copy only loads the carry; the word that brings
  // the last source bytes also flushes its own leftover bytes into one more destination word.
  always_comb begin
    head   = (phase_q == PH_HEAD);
    kill   = (phase_q == PH_DONE) || (head && (left_q == '0));
    skip_a = head && lag;
    take   = head ? (LEN_W'(src_lane) + LEN_W'(1)) : LEN_W'(WORD_BYTES);
    left_next = (take >= left_q) ? '0 : left_q - take;
    last   = (left_next == '0);
    pos_b  = skip_a ? pos_q : pos_q + POS_W'(1);
    base_b = skip_a ? base_q : base_step(pos_q, base_q);
  end

  rrwc_build #(.WORD_BYTES(WORD_BYTES)) u_build_a (
    .older_i (carry_q),
    .newer_i (in_word_q),
    .shift_i (shift),
    .md_i    (md),
    .span_i  (span),
    .base_i  (base_q),
    .pos_i   (pos_q),
    .res_o   (res_a),
    .any_o   (any_a)
  );

  rrwc_build #(.WORD_BYTES(WORD_BYTES)) u_build_b (
    .older_i (in_word_q),
    .newer_i ('0),
    .shift_i (shift),
    .md_i    (md),
    .span_i  (span),
    .base_i  (base_b),
    .pos_i   (pos_b),
    .res_o   (res_b),
    .any_o   (any_b)
  );

  assign emit_a = consume && !kill && !skip_a && any_a;
  assign emit_b = consume && !kill && last && any_b;
  assign push_n = 2'(emit_a) + 2'(emit_b);

  always_comb begin
    carry_d = carry_q;
    left_d  = left_q;
    pos_d   = pos_q;
    base_d  = base_q;
    phase_d = phase_q;
    if (restart) begin
      carry_d = '0;
      left_d  = len_d;
      pos_d   = '0;
      base_d  = '0;
      phase_d = PH_HEAD;
    end else if (consume) begin
      if (kill) begin
        phase_d = PH_DONE;
      end else begin
        carry_d = in_word_q;
        left_d  = left_next;
        pos_d   = pos_b;
        base_d  = base_b;
        if (emit_b) begin
          pos_d  = pos_b + POS_W'(1);
          base_d = base_step(pos_b, base_b);
        end
        phase_d = last ? PH_DONE : PH_STREAM;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cfg_q  <= '0;
      dst_cfg_q  <= '0;
      len_q      <= '0;
      carry_q    <= '0;
      left_q     <= '0;
      pos_q      <= '0;
      base_q     <= '0;
      phase_q    <= PH_HEAD;
      in_valid_q <= 1'b0;
    end else begin
      src_cfg_q  <= src_cfg_d;
      dst_cfg_q  <= dst_cfg_d;
      len_q      <= len_d;
      carry_q    <= carry_d;
      left_q     <= left_d;
      pos_q      <= pos_d;
      base_q     <= base_d;
      phase_q    <= phase_d;
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_word_q <= s_axis_tdata;
    end
  end

  rrwc_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (emit_a ? res_a : res_b),
    .push1_i  (res_b),
    .room2_o  (room2),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .head_o   (fifo_head)
  );

  assign m_axis_tdata = {2'b00, fifo_head.word_back_index, fifo_head.byte_enable,
                         fifo_head.dst_word};
  assign m_axis_tlast = fifo_head.final_word;

endmodule

### bench/tb_reverse_realigning_word_copy.sv
// Self-checking bench for reverse_realigning_word_copy: drives descending source words,
// predicts each destination word with its byte enables and checks the output stream.
// Depends on rrwc_pkg and the reverse_realigning_word_copy RTL.
`timescale 1ns / 100ps

module tb_reverse_realigning_word_copy;
  import rrwc_pkg::*;

  localparam int unsigned WB           = DEFAULT_WORD_BYTES;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          ITEM_TARGET  = 1700;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Source word fill patterns.
  localparam int PAT_RANDOM = 0;
  localparam int PAT_ONES   = 1;
  localparam int PAT_ZEROS  = 2;
  localparam int PAT_ALT    = 3;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx       = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [63:0] src_word
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [63:0] dst_word, [71:64] byte_enable,
                                                // [101:72] word_back_index
  logic                   m_axis_tlast;         // final_word

  reverse_realigning_word_copy #(.WORD_BYTES(WB)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Copy predictor: configuration and running state.
  logic [LANE_W-1:0] src_lane    = '0;
  logic [LANE_W-1:0] dst_lane    = '0;
  logic [LEN_W-1:0]  copy_len    = '0;
  logic [DATA_W-1:0] carry_word  = '0;
  int unsigned       shift_bytes = 0;
  logic [LEN_W-1:0]  left_bytes  = '0;
  logic [POS_W-1:0]  next_pos    = '0;
  phase_e            copy_phase  = PH_HEAD;

  res_t              expected_words[$];
  logic [DATA_W-1:0] pending_src[$];

  int  pushed_cnt   = 0;
  int  accepted_cnt = 0;
  int  items_sent   = 0;
  int  fail_cnt     = 0;
  int  cycle_cnt    = 0;
  bit  in_taken     = 1'b0;
  bit  out_taken    = 1'b0;
  bit  in_busy      = 1'b0;
  int  in_gap       = 0;
  int  out_wait     = 0;
  bit  no_stall     = 1'b0;

  function automatic void restart_copy();
    carry_word  = '0;
    shift_bytes = (int'(dst_lane) % WB + WB - int'(src_lane) % WB) % WB;
    left_bytes  = copy_len;
    next_pos    = '0;
    copy_phase  = PH_HEAD;
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_SRC_END_LANE: begin src_lane = v[LANE_W-1:0]; restart_copy(); end
      REG_DST_END_LANE: begin dst_lane = v[LANE_W-1:0]; restart_copy(); end
      REG_BYTE_LENGTH:  begin copy_len = v[LEN_W-1:0];  restart_copy(); end
      default: ;
    endcase
  endfunction

  // Builds destination word k; returns 0 when none of its lanes lies in the range.
  function automatic bit merge_word(logic [DATA_W-1:0] older, logic [DATA_W-1:0] newer,
                                    logic [POS_W-1:0] k, output res_t r);
    longint unsigned p, md, n, words;
    int unsigned     lsrc;
    logic [BE_W-1:0] en;
    r  = '0;
    en = '0;
    md = WB - 1 - int'(dst_lane) % WB;
    n  = longint'(copy_len);
    for (int lane = 0; lane < WB; lane++) begin
      p = longint'(k) * WB + (WB - 1 - lane);
      if (shift_bytes == 0 || lane < shift_bytes) begin
        lsrc = (lane + WB - shift_bytes) % WB;
        r.dst_word[8*lane +: 8] = newer[8*lsrc +: 8];
      end else begin
        lsrc = lane - shift_bytes;
        r.dst_word[8*lane +: 8] = older[8*lsrc +: 8];
      end
      if (p >= md && p - md < n) en[lane] = 1'b1;
    end
    if (en == '0) return 1'b0;
    words             = (n + md + WB - 1) / WB;
    r.byte_enable     = en;
    r.word_back_index = k;
    r.final_word      = (longint'(k) + 1 == words);
    return 1'b1;
  endfunction

  function automatic void advance_copy(logic [DATA_W-1:0] cur);
    bit          first, lag;
    int unsigned take;
    res_t        r;
    first = (copy_phase == PH_HEAD);
    lag   = (int'(src_lane) % WB) < (int'(dst_lane) % WB);
    if (copy_phase == PH_DONE || (first && left_bytes == 0)) begin
      copy_phase = PH_DONE;
      return;
    end
    take = first ? int'(src_lane) % WB + 1 : WB;
    if (take > left_bytes) take = left_bytes;
    left_bytes -= take;
    // With the destination end lane above the source one, the head word only fills the carry.
    if (!(first && lag)) begin
      if (merge_word(carry_word, cur, next_pos, r)) expected_words.push_back(r);
      next_pos++;
    end
    carry_word = cur;
    if (left_bytes == 0) begin
      if (merge_word(cur, '0, next_pos, r)) begin
        expected_words.push_back(r);
        next_pos++;
      end
      copy_phase = PH_DONE;
    end else begin
      copy_phase = PH_STREAM;
    end
  endfunction

  // Source words still needed to finish the copy in progress.
  function automatic longint words_to_finish();
    longint rem;
    rem = longint'(left_bytes);
    case (copy_phase)
      PH_DONE:   return 0;
      PH_STREAM: return (rem + WB - 1) / WB;
      default: begin
        if (rem == 0) return 1;
        rem -= (rem < int'(src_lane) % WB + 1) ? rem : int'(src_lane) % WB + 1;
        return 1 + (rem + WB - 1) / WB;
      end
    endcase
  endfunction

  // Source driver.
  always @(negedge clk_i) begin
    if (in_busy && in_taken) in_busy = 1'b0;
    if (!in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_src.size() > 0) begin
        s_axis_tdata <= pending_src.pop_front();
        in_busy = 1'b1;
        in_gap  = no_stall ? 0 : $urandom_range(0, 3);
      end
    end
    s_axis_tvalid <= in_busy;
  end

  // Destination back-pressure.
  always @(negedge clk_i) begin
    if (out_taken) out_wait = no_stall ? 0 : $urandom_range(0, 3);
    if (out_wait > 0) begin
      out_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: register writes, source acceptance and destination checks.
  always @(posedge clk_i) begin
    res_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("reverse_realigning_word_copy test failed");
      $finish;
    end else begin
      in_taken  = s_axis_tvalid && s_axis_tready;
      out_taken = m_axis_tvalid && m_axis_tready;
      if (cfg_we) apply_write(cfg_idx, cfg_data);
      if (in_taken) begin
        advance_copy(s_axis_tdata[DATA_W-1:0]);
        accepted_cnt++;
      end
      if (out_taken) begin
        if (expected_words.size() == 0) begin
          $error("destination word with nothing expected: tdata %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata[63:0] !== want.dst_word) begin
            $error("dst_word: expected %h, got %h", want.dst_word, m_axis_tdata[63:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[71:64] !== want.byte_enable) begin
            $error("byte_enable: expected %h, got %h", want.byte_enable, m_axis_tdata[71:64]);
            fail_cnt++;
          end
          if (m_axis_tdata[101:72] !== want.word_back_index) begin
            $error("word_back_index: expected %0d, got %0d", want.word_back_index,
                   m_axis_tdata[101:72]);
            fail_cnt++;
          end
          if (m_axis_tlast !== want.final_word) begin
            $error("final_word: expected %b, got %b", want.final_word, m_axis_tlast);
            fail_cnt++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
  endtask

  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // One copy: optional register writes, then the source words, then wait for the block to idle.
  task automatic copy_run(bit wr_src, bit wr_dst, bit wr_len, bit wr_unused,
                          logic [31:0] src_v, logic [31:0] dst_v, logic [31:0] len_v,
                          int cap, int extra, int pattern);
    longint            needed;
    int                n;
    logic [DATA_W-1:0] w;
    if (wr_src)    write_reg(REG_SRC_END_LANE, src_v);
    if (wr_dst)    write_reg(REG_DST_END_LANE, dst_v);
    if (wr_len)    write_reg(REG_BYTE_LENGTH, len_v);
    if (wr_unused) write_reg(REG_UNUSED, $urandom());
    if (wr_src || wr_dst || wr_len || wr_unused) begin
      @(negedge clk_i);
      cfg_we <= 1'b0;
    end
    needed = words_to_finish();
    // Long copies are cut short; a later register write restarts them.
    if (cap < 0 && needed > 64) cap = $urandom_range(1, 6);
    n = (cap >= 0 && cap < needed) ? cap : int'(needed);
    for (int i = 0; i < n + extra; i++) begin
      case (pattern)
        PAT_ONES:  w = '1;
        PAT_ZEROS: w = '0;
        PAT_ALT:   w = i[0] ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA;
        default:   w = {$urandom(), $urandom()};
      endcase
      pending_src.push_back(w);
      pushed_cnt++;
    end
    items_sent += n;
    wait_drained();
  endtask

  initial begin
    int          mode, cap, extra;
    bit          restart;
    logic [31:0] len_v;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed copies: lane extremes, both shift directions, zero length, input after done,
    // lanes given above the word size, the longest length and a write to the unused index.
    copy_run(1, 1, 1, 0, 0, 0, 1, -1, 0, PAT_ONES);
    copy_run(1, 1, 1, 0, 7, 7, 8, -1, 0, PAT_ONES);
    copy_run(1, 1, 1, 0, 0, 7, 16, -1, 0, PAT_ALT);
    copy_run(1, 1, 1, 0, 7, 0, 16, -1, 0, PAT_RANDOM);
    copy_run(1, 1, 1, 0, 3, 5, 0, -1, 1, PAT_RANDOM);
    copy_run(1, 1, 1, 0, 2, 6, 21, -1, 1, PAT_RANDOM);
    copy_run(1, 1, 1, 0, 6, 1, 3, -1, 0, PAT_RANDOM);
    copy_run(1, 1, 1, 0, 32'hFFFF_FFFD, 32'h8000_0002, 32'hFFFF_FFFF, 3, 0, PAT_ZEROS);
    copy_run(0, 0, 0, 0, 0, 0, 0, 2, 0, PAT_ONES);
    copy_run(0, 0, 0, 1, 0, 0, 0, 1, 0, PAT_RANDOM);

    while (items_sent < ITEM_TARGET) begin
      no_stall = ($urandom_range(0, 4) == 0);
      mode     = $urandom_range(0, 19);
      case (mode)
        0:       len_v = 0;
        1:       len_v = $urandom();
        2:       len_v = 32'hFFFF_FFFF;
        3, 4, 5: len_v = $urandom_range(41, 200);
        default: len_v = $urandom_range(1, 40);
      endcase
      restart = ($urandom_range(0, 9) != 0);
      cap     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : -1;
      extra   = ($urandom_range(0, 5) > 3) ? $urandom_range(1, 2) : 0;
      copy_run(restart && $urandom_range(0, 1), restart && $urandom_range(0, 1), restart,
               !restart && $urandom_range(0, 1), $urandom(), $urandom(), len_v,
               cap, extra, PAT_RANDOM);
    end

    no_stall = 1'b0;
    wait_drained();
    if (fail_cnt == 0) begin
      $display("reverse_realigning_word_copy test passed");
    end else begin
      $display("reverse_realigning_word_copy test failed");
    end
    $finish;
  end

endmodule

### reverse_realigning_word_copy.f
rtl/core/rrwc_pkg.sv
rtl/core/rrwc_build.sv
rtl/core/rrwc_res_fifo.sv
rtl/core/reverse_realigning_word_copy.sv
bench/tb_reverse_realigning_word_copy.sv
